[design/rta_pkg.sv]
// shared types and constants for the ray transport accumulator
package rta_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [16:0] trans_t;
    typedef logic [31:0] emit_t;

    localparam mode_t  MODE_EMIT  = 2'd0;
    localparam mode_t  MODE_TRANS = 2'd1;
    localparam mode_t  MODE_BOTH  = 2'd2;

    localparam logic   REG_MODE   = 1'b0;

    localparam trans_t ONE_Q16    = 17'd65536;
    localparam emit_t  SAT32      = 32'hFFFF_FFFF;

endpackage

[design/rta_mac.sv]
// per-group transmission and emission update, one segment per cycle
module rta_mac
    import rta_pkg::*;
(
    input  mode_t  mode,
    input  trans_t base_tr,
    input  emit_t  base_em,
    input  trans_t t,
    input  emit_t  s,
    output trans_t tr_new,
    output emit_t  em_new
);

    logic [33:0] tr_prod;
    logic [48:0] em_prod;
    logic [32:0] em_scaled;
    logic [33:0] em_sum_w;
    logic [33:0] em_sum_p;

    always_comb
    begin
        tr_prod   = {17'd0, base_tr} * {17'd0, t};
        em_prod   = {17'd0, base_em} * {32'd0, t};
        em_scaled = em_prod[48:16];
        em_sum_w  = {1'b0, em_scaled} + {2'd0, s};
        em_sum_p  = {2'd0, base_em} + {2'd0, s};
        tr_new    = tr_prod[32:16];
        case (mode)
            MODE_EMIT:
            begin
                em_new = (em_sum_p > {2'd0, SAT32}) ? SAT32 : em_sum_p[31:0];
            end
            MODE_TRANS:
            begin
                em_new = base_em;
            end
            default:
            begin
                em_new = (em_sum_w > {2'd0, SAT32}) ? SAT32 : em_sum_w[31:0];
            end
        endcase
    end

endmodule

[design/ray_transport_accumulator_top.sv]
// top level of the ray transport accumulator
// path: an accepted item is registered into stage 1, and an emitting item then into the result register
// throughput: one transaction per cycle unless the output stalls; read-modify-write
// of the group memory, with the last write forwarded to a following same-group item
// reset: mode goes to both, all group entries read as 1.0 and 0 through cleared
// valid bits, so there is no clearing pass
module ray_transport_accumulator_top
    import rta_pkg::*;
#(
    parameter int GROUPS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        seg_valid,
    output logic        seg_ready,
    input  logic        kind,
    input  logic [5:0]  group,
    input  logic [16:0] transmission,
    input  logic [31:0] emission,
    input  logic        first_segment,
    input  logic        last_segment,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [5:0]  group_out,
    output logic [16:0] transmission_out,
    output logic [31:0] emission_out
);

    localparam int DEPTH = (GROUPS < 64) ? GROUPS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    trans_t tr_mem [DEPTH];
    emit_t  em_mem [DEPTH];

    mode_t            mode_reg, mode_next;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             res_valid_reg, res_valid_next;

    logic             s1_kind_reg;
    logic [5:0]       s1_group_reg;
    logic [AW-1:0]    s1_addr_reg;
    trans_t           s1_t_reg;
    emit_t            s1_s_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    logic             rd_vld_reg;
    trans_t           rd_tr_reg;
    emit_t            rd_em_reg;
    trans_t           last_tr_reg;
    emit_t            last_em_reg;
    logic [5:0]       group_out_reg;
    trans_t           tr_out_reg;
    emit_t            em_out_reg;

    logic             cfg_wr;
    logic             seg_fire;
    logic             in_range;
    logic [AW-1:0]    in_addr;
    trans_t           t_clamped;
    logic             s1_emits;
    logic             out_free;
    logic             s1_go;
    logic             wr_en;
    trans_t           stored_tr;
    emit_t            stored_em;
    trans_t           base_tr;
    emit_t            base_em;
    trans_t           tr_new;
    emit_t            em_new;
    trans_t           tr_res;
    emit_t            em_res;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_reg} : 32'd0;

    // input side
    assign in_range  = ({5'd0, group} < 11'(GROUPS));
    assign in_addr   = group[AW-1:0];
    assign t_clamped = (transmission > ONE_Q16) ? ONE_Q16 : transmission;
    assign seg_ready = !s1_valid_reg || s1_go;
    assign seg_fire  = seg_valid && seg_ready;

    // stage 1 control
    assign s1_emits = s1_kind_reg || s1_last_reg;
    assign out_free = !res_valid_reg || res_ready;
    assign s1_go    = s1_valid_reg && (!s1_emits || out_free);
    assign wr_en    = s1_go && !s1_kind_reg;

    // stored state with forwarding of the write made at the read edge
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            stored_tr = last_tr_reg;
            stored_em = last_em_reg;
        end
        else if (rd_vld_reg)
        begin
            stored_tr = rd_tr_reg;
            stored_em = rd_em_reg;
        end
        else
        begin
            stored_tr = ONE_Q16;
            stored_em = '0;
        end
        base_tr = s1_first_reg ? ONE_Q16 : stored_tr;
        base_em = s1_first_reg ? '0 : stored_em;
    end

    rta_mac u_mac
    (
        .mode    (mode_reg),
        .base_tr (base_tr),
        .base_em (base_em),
        .t       (s1_t_reg),
        .s       (s1_s_reg),
        .tr_new  (tr_new),
        .em_new  (em_new)
    );

    always_comb
    begin
        tr_res = s1_kind_reg ? ONE_Q16 : tr_new;
        em_res = s1_kind_reg ? '0 : em_new;
        if (mode_reg == MODE_EMIT)
        begin
            tr_res = ONE_Q16;
        end
        if (mode_reg == MODE_TRANS)
        begin
            em_res = '0;
        end
    end

    // next values of control state
    always_comb
    begin
        mode_next = cfg_wr && (paddr[2] == REG_MODE) ? pwdata[1:0] : mode_reg;
        vld_next  = vld_reg;
        if (wr_en)
        begin
            vld_next[s1_addr_reg] = 1'b1;
        end
        if (seg_fire)
        begin
            s1_valid_next = in_range;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_go && s1_emits)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BOTH;
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            vld_reg       <= vld_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // group memory: registered read at accept, write back from stage 1
    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            rd_tr_reg  <= tr_mem[in_addr];
            rd_em_reg  <= em_mem[in_addr];
        end
        if (wr_en)
        begin
            tr_mem[s1_addr_reg] <= tr_new;
            em_mem[s1_addr_reg] <= em_new;
        end
    end

    // stage 1 and result payload
    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            s1_kind_reg  <= kind;
            s1_group_reg <= group;
            s1_addr_reg  <= in_addr;
            s1_t_reg     <= t_clamped;
            s1_s_reg     <= emission;
            s1_first_reg <= first_segment;
            s1_last_reg  <= last_segment;
            s1_fwd_reg   <= wr_en && (s1_addr_reg == in_addr);
            rd_vld_reg   <= vld_reg[in_addr];
        end
        if (wr_en)
        begin
            last_tr_reg <= tr_new;
            last_em_reg <= em_new;
        end
        if (s1_go && s1_emits)
        begin
            group_out_reg <= s1_group_reg;
            tr_out_reg    <= tr_res;
            em_out_reg    <= em_res;
        end
    end

    assign res_valid        = res_valid_reg;
    assign group_out        = group_out_reg;
    assign transmission_out = tr_out_reg;
    assign emission_out     = em_out_reg;

`ifndef SYNTHESIS
    a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emits && res_valid_reg && !res_ready) |-> !s1_go)
        else $error("stage 1 advanced into a stalled result register");

    a_tr_range : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (tr_new <= ONE_Q16))
        else $error("transmission state above one");

    a_fwd_only_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && seg_fire && in_range && (s1_addr_reg == in_addr)) |=> s1_fwd_reg)
        else $error("same-group write not forwarded");

    a_res_load : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emits) |=> res_valid_reg)
        else $error("emitting item produced no transaction");
`endif

endmodule

[tb/tb_ray_transport_accumulator_top.sv]
// self-checking testbench for the ray transport accumulator top level
`timescale 1ns / 100ps

module tb_ray_transport_accumulator_top
    import rta_pkg::*;
;

    localparam mode_t MODE_SPARE = 2'd3;
    localparam int    NUM_GROUPS = 64;

    typedef struct packed {
        logic       kind;
        logic [5:0] grp;
        trans_t     t;
        emit_t      s;
        logic       first;
        logic       last;
    } segment_t;

    typedef struct packed {
        logic [5:0] grp;
        trans_t     tr;
        emit_t      em;
    } ray_total_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        seg_valid = 1'b0;
    logic        seg_ready;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [5:0]  group_out;
    logic [16:0] transmission_out;
    logic [31:0] emission_out;

    segment_t    cur_seg = '0;
    segment_t    segment_q[$];
    ray_total_t  ray_totals_q[$];

    trans_t      trans_acc [NUM_GROUPS];
    emit_t       emit_acc [NUM_GROUPS];
    mode_t       mode_shadow = MODE_BOTH;

    logic        no_idle = 1'b0;
    logic        long_hold = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          accepted_cnt = 0;
    int          fail_cnt = 0;

    mode_t       phase_mode [0:5] = '{MODE_BOTH, MODE_EMIT, MODE_TRANS, MODE_SPARE,
                                      MODE_EMIT, MODE_BOTH};
    int          phase_items [0:5] = '{150, 110, 110, 70, 80, 180};

    always #5 clk = ~clk;

    ray_transport_accumulator_top #(
        .GROUPS(NUM_GROUPS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .seg_valid(seg_valid),
        .seg_ready(seg_ready),
        .kind(cur_seg.kind),
        .group(cur_seg.grp),
        .transmission(cur_seg.t),
        .emission(cur_seg.s),
        .first_segment(cur_seg.first),
        .last_segment(cur_seg.last),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .group_out(group_out),
        .transmission_out(transmission_out),
        .emission_out(emission_out)
    );

    function automatic emit_t add_saturate(input emit_t a, input emit_t b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? SAT32 : sum[31:0];
    endfunction

    task automatic integrate_segment(input segment_t seg);
        trans_t      t;
        trans_t      tr;
        emit_t       em;
        logic [48:0] em_prod;
        logic [33:0] tr_prod;
        ray_total_t  total;
        if (seg.kind)
        begin
            tr = ONE_Q16;
            em = '0;
        end
        else
        begin
            t = (seg.t > ONE_Q16) ? ONE_Q16 : seg.t;
            if (seg.first)
            begin
                tr = ONE_Q16;
                em = '0;
            end
            else
            begin
                tr = (trans_acc[seg.grp] > ONE_Q16) ? ONE_Q16 : trans_acc[seg.grp];
                em = emit_acc[seg.grp];
            end
            if (mode_shadow == MODE_EMIT)
            begin
                em = add_saturate(em, seg.s);
            end
            else if (mode_shadow != MODE_TRANS)
            begin
                em_prod = {17'd0, em} * {32'd0, t};
                em = add_saturate(em_prod[47:16], seg.s);
            end
            tr_prod = {17'd0, tr} * {17'd0, t};
            tr = tr_prod[32:16];
            trans_acc[seg.grp] = tr;
            emit_acc[seg.grp] = em;
            if (!seg.last)
                return;
        end
        if (mode_shadow == MODE_EMIT)
            tr = ONE_Q16;
        if (mode_shadow == MODE_TRANS)
            em = '0;
        total = {seg.grp, tr, em};
        ray_totals_q.push_back(total);
    endtask

    // segment driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid <= 1'b0;
            cur_seg <= '0;
            send_gap <= 0;
            accepted_cnt <= 0;
        end
        else
        begin
            if (seg_valid && seg_ready)
            begin
                integrate_segment(cur_seg);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!seg_valid || seg_ready)
            begin
                if (send_gap != 0)
                begin
                    seg_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (segment_q.size() != 0)
                begin
                    cur_seg <= segment_q.pop_front();
                    seg_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 15);
                end
                else
                begin
                    seg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (ray_totals_q.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("unexpected result: grp %0d tr %0d em %h",
                                 group_out, transmission_out, emission_out);
                    fail_cnt <= fail_cnt + 1;
                end
                else
                begin
                    ray_total_t exp_total;
                    exp_total = ray_totals_q.pop_front();
                    if (group_out !== exp_total.grp || transmission_out !== exp_total.tr ||
                        emission_out !== exp_total.em)
                    begin
                        if (fail_cnt < 10)
                            $display({"mismatch: exp grp %0d tr %0d em %h, ",
                                      "got grp %0d tr %0d em %h"},
                                     exp_total.grp, exp_total.tr, exp_total.em,
                                     group_out, transmission_out, emission_out);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
            if (long_hold)
            begin
                res_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                res_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                res_ready <= 1'b0;
                recv_gap <= $urandom_range(0, 14);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        while (!rst_n || accepted_cnt < 60)
            @(negedge clk);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_ray_transport_accumulator_top: done, errors");
        $finish;
    end

    task automatic write_mode(input mode_t m);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MODE, 2'b00};
        pwdata <= {30'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic push_seg(input logic k, input logic [5:0] g, input trans_t t,
                            input emit_t s, input logic f, input logic l);
        segment_q.push_back({k, g, t, s, f, l});
    endtask

    function automatic trans_t rand_trans();
        case ($urandom_range(0, 5))
            0: return ONE_Q16;
            1: return trans_t'($urandom_range(65537, 131071));
            2: return '0;
            3: return trans_t'($urandom_range(60000, 65536));
            default: return trans_t'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic emit_t rand_emit();
        case ($urandom_range(0, 3))
            0: return SAT32;
            1: return emit_t'($urandom_range(0, 65535));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [5:0] pick_group();
        if ($urandom_range(0, 1))
            return 6'($urandom_range(0, 3));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic queue_directed();
        push_seg(1'b0, 6'd0, ONE_Q16, 32'd5, 1'b0, 1'b1);
        push_seg(1'b0, 6'd1, 17'd0, 32'd0, 1'b0, 1'b0);
        push_seg(1'b0, 6'd1, 17'h08000, SAT32, 1'b0, 1'b1);
        push_seg(1'b0, 6'd63, 17'h1FFFF, SAT32, 1'b1, 1'b1);
        push_seg(1'b0, 6'd63, 17'd0, 32'd0, 1'b1, 1'b1);
        push_seg(1'b1, 6'd2, 17'h1FFFF, SAT32, 1'b1, 1'b1);
        push_seg(1'b1, 6'd0, 17'd0, 32'd0, 1'b0, 1'b0);
        push_seg(1'b0, 6'd10, 17'h0C000, 32'h1000_0000, 1'b1, 1'b0);
        push_seg(1'b0, 6'd10, 17'h1FFFF, SAT32, 1'b0, 1'b0);
        push_seg(1'b0, 6'd10, 17'h04000, 32'd1, 1'b0, 1'b1);
        push_seg(1'b0, 6'd20, ONE_Q16, SAT32, 1'b1, 1'b0);
        push_seg(1'b0, 6'd20, ONE_Q16, SAT32, 1'b0, 1'b1);
        push_seg(1'b0, 6'd30, 17'h0F000, 32'h0001_0000, 1'b1, 1'b0);
        push_seg(1'b0, 6'd31, 17'h08000, 32'h0002_0000, 1'b1, 1'b0);
        push_seg(1'b0, 6'd30, 17'h0A000, 32'h0003_0000, 1'b0, 1'b1);
        push_seg(1'b0, 6'd31, 17'h10001, 32'hFFFF_0000, 1'b0, 1'b1);
        push_seg(1'b0, 6'd40, 17'h0ABCD, 32'h1234_5678, 1'b1, 1'b0);
    endtask

    task automatic queue_random_items(input int n);
        int         made;
        int         len;
        logic [5:0] g;
        made = 0;
        while (made < n)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    push_seg(1'b1, 6'($urandom_range(0, 63)), trans_t'($urandom_range(0, 131071)),
                             $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    made++;
                end
                8, 9:
                begin
                    push_seg(1'($urandom_range(0, 1)), pick_group(), rand_trans(), rand_emit(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    made++;
                end
                default:
                begin
                    len = $urandom_range(1, 5);
                    g = pick_group();
                    for (int i = 0; i < len; i++)
                        push_seg(1'b0, g, rand_trans(), rand_emit(), i == 0, i == len - 1);
                    made += len;
                end
            endcase
        end
    endtask

    task automatic settle();
        while (segment_q.size() != 0 || seg_valid || ray_totals_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            trans_acc[g] = ONE_Q16;
            emit_acc[g] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 6; p++)
        begin
            write_mode(phase_mode[p]);
            if (p == 5)
                no_idle <= 1'b1;
            @(negedge clk);
            if (p == 0)
                queue_directed();
            queue_random_items(phase_items[p]);
            settle();
        end
        repeat (8) @(posedge clk);
        if (fail_cnt == 0 && ray_totals_q.size() == 0)
            $display("tb_ray_transport_accumulator_top: done, clean");
        else
            $display("tb_ray_transport_accumulator_top: done, errors");
        $finish;
    end

endmodule
